// ===== src/hcbp_pkg.sv =====
// hcbp_pkg: shared types and constants for the code table bit packer
// no dependencies; imported by every module of the block except hcbp_ram
package hcbp_pkg;

  localparam int SYMBOL_W = 9;
  localparam int CODE_LEN_W = 6;
  localparam int CODE_BITS_W = 32;
  localparam int BYTE_W = 8;

  // operation codes of an input item
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]             op;
    logic [SYMBOL_W-1:0]    symbol;
    logic [CODE_LEN_W-1:0]  code_length;
    logic [CODE_BITS_W-1:0] code_bits;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } rsp_t;

  // commands from the sequencer to the accumulator
  typedef struct packed {
    logic merge;
    logic shift;
    logic clear;
  } pack_ctrl_t;

endpackage

// ===== src/hcbp_ram.sv =====
// hcbp_ram: generic single write port, single read port ram, registered read
// no dependencies
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hcbp_packer.sv =====
// hcbp_packer: bit accumulator with merge and byte shift unit
// depends on hcbp_pkg for the control struct
module hcbp_packer #(
  parameter int LEN_LIM = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  hcbp_pkg::pack_ctrl_t                   ctrl,
  input  logic [$clog2(LEN_LIM+1)-1:0]           code_len,
  input  logic [LEN_LIM-1:0]                     code_bits,
  output logic [7:0]                             low_byte,
  output logic [$clog2(LEN_LIM+7+1)-1:0]         count
);
  import hcbp_pkg::*;

  localparam int ACC_W = LEN_LIM + 7;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] acc;

  // held bits above count are always zero, so a pad byte is just the low byte
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
      count <= '0;
    end else if (ctrl.merge) begin
      acc <= acc | (ACC_W'(code_bits) << count[2:0]);
      count <= count + CNT_W'(code_len);
    end else if (ctrl.shift) begin
      acc <= acc >> BYTE_W;
      count <= count - CNT_W'(BYTE_W);
    end
  end

  assign low_byte = acc[7:0];

endmodule

// ===== src/huffman_code_bit_packer.sv =====
// Code table bit packer: a load item writes one symbol's code (length and
// bits, first bit in bit 0) into a table memory; an encode item looks up a
// symbol and appends its code to a bit accumulator, emitting every full byte
// with the earliest bit in bit 0; a finish item appends the end-marker code
// (entry NUM_SYMBOLS-1), pads a partial byte with zeros and flags the final
// byte with last. Lengths above the smaller of MAX_CODE_LEN and 32 saturate.
// After reset a clearing pass zeroes the table, one entry per cycle, during
// which req_ready stays low. An encode or finish item passes through accept
// with table read, merge and a final emit check, each full output byte
// taking an emit step of its own before that check and a pad byte standing
// in for it; a stall on rsp_ready holds an emit step. The single byte shift
// unit of the accumulator moves out one byte at a time. Symbols outside the
// table are ignored by load and encode items. A new item is accepted while
// the last byte still waits in the output register.
// Depends on hcbp_pkg, hcbp_ram and hcbp_packer.
module huffman_code_bit_packer #(
  parameter int NUM_SYMBOLS = 257,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  hcbp_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output hcbp_pkg::rsp_t rsp
);
  import hcbp_pkg::*;

  // effective code length limit
  localparam int LEN_LIM = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
  localparam int LEN_W = $clog2(LEN_LIM + 1);
  localparam int ENTRY_W = LEN_W + LEN_LIM;
  localparam int AW = $clog2(NUM_SYMBOLS);
  localparam int CNT_W = $clog2(LEN_LIM + 7 + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MERGE,
    ST_EMIT
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic finishing;        // current item is a finish
  logic hit;              // looked-up symbol lies inside the table

  // table memory ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // accumulator
  pack_ctrl_t       pk_ctrl;
  logic [7:0]       pk_byte;
  logic [CNT_W-1:0] pk_count;

  logic accept;
  logic sym_in_range;
  logic [LEN_W-1:0] load_len;
  logic [LEN_LIM-1:0] load_mask;
  logic slot_free;
  logic full_byte;        // at least one whole byte held
  logic pad_pending;      // finish with a partial byte left
  logic emit_fire;

  assign req_ready = (state == ST_IDLE);
  assign accept = req_valid && req_ready;
  assign sym_in_range = (32'(req.symbol) < NUM_SYMBOLS);

  // saturate the length, then clear bits above it
  assign load_len = (req.code_length > CODE_LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM)
                                                              : LEN_W'(req.code_length);
  assign load_mask = ~({LEN_LIM{1'b1}} << load_len);

  // table writes come from the clearing pass or a load item
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we = accept && (req.op == OP_LOAD) && sym_in_range;
      ram_waddr = AW'(req.symbol);
      ram_wdata = {load_len, req.code_bits[LEN_LIM-1:0] & load_mask};
    end
  end

  // finish reads the end-marker entry, encode its own symbol
  assign ram_raddr = (req.op == OP_FINISH) ? AW'(NUM_SYMBOLS - 1) : AW'(req.symbol);

  hcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_SYMBOLS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // byte emission: output register is free or drains this cycle
  assign slot_free = !rsp_valid || rsp_ready;
  assign full_byte = (pk_count >= CNT_W'(BYTE_W));
  assign pad_pending = finishing && (pk_count != '0);
  assign emit_fire = (state == ST_EMIT) && slot_free && (full_byte || pad_pending);

  always_comb begin
    pk_ctrl.merge = (state == ST_MERGE) && hit;
    pk_ctrl.shift = emit_fire && full_byte;
    pk_ctrl.clear = emit_fire && !full_byte;
  end

  hcbp_packer #(
    .LEN_LIM(LEN_LIM)
  ) u_packer (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (pk_ctrl),
    .code_len (ram_rdata[ENTRY_W-1:LEN_LIM]),
    .code_bits(ram_rdata[LEN_LIM-1:0]),
    .low_byte (pk_byte),
    .count    (pk_count)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      finishing <= 1'b0;
      hit <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        rsp_valid <= 1'b1;
        rsp.out_byte <= pk_byte;
        // final byte of a finish: exactly one byte held, or the pad byte
        rsp.last <= finishing && (pk_count <= CNT_W'(BYTE_W));
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(NUM_SYMBOLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (req.op == OP_ENCODE || req.op == OP_FINISH)) begin
            finishing <= (req.op == OP_FINISH);
            hit <= (req.op == OP_FINISH) || sym_in_range;
            state <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (full_byte) begin
            state <= ST_EMIT;
          end else if (pad_pending && !slot_free) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/hcbp_checker.sv =====
// hcbp_checker: port-level assertions for the code table bit packer
// depends on hcbp_pkg; bound to huffman_code_bit_packer below
module hcbp_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input hcbp_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input hcbp_pkg::rsp_t rsp
);
  import hcbp_pkg::*;

  // a stalled output item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("output item changed while stalled");

  // reset starts the table clearing pass with nothing in flight
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("block not quiet after reset");

  // a load item never brings an output item with it
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.op == OP_LOAD && !rsp_valid |=> !rsp_valid)
    else $error("load item produced output");

  // encode and finish occupy the block: req_ready drops once one is accepted
  a_busy_after_code: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.op == OP_ENCODE || req.op == OP_FINISH)
    |=> !req_ready)
    else $error("ready right after encode or finish");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
